/* hw/rtl/hpfc_pkg.sv */
// Package: item types, action codes and conversion functions for the format converter
package hpfc_pkg;

    localparam logic [1:0] ACT_NARROW = 2'd0;
    localparam logic [1:0] ACT_WIDEN32 = 2'd1;
    localparam logic [1:0] ACT_WIDEN64 = 2'd2;

    localparam logic [2:0] CLS_ZERO = 3'd0;
    localparam logic [2:0] CLS_FINITE = 3'd1;
    localparam logic [2:0] CLS_POS_INF = 3'd2;
    localparam logic [2:0] CLS_NEG_INF = 3'd3;
    localparam logic [2:0] CLS_NAN = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] operand_bits;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_bits;
        logic [2:0]  half_class;
    } out_item_t;

    function automatic logic [15:0] narrow_to_half(input logic [31:0] x);
        logic        sgn;
        logic [7:0]  e;
        logic [22:0] m;
        logic [14:0] h;
        logic [12:0] rem;
        logic [23:0] sig;
        logic [4:0]  sh;
        logic [23:0] rm;
        logic [23:0] hf;
        logic [10:0] q;
        begin
            sgn = x[31];
            e   = x[30:23];
            m   = x[22:0];
            h   = 15'd0;
            rem = m[12:0];
            sig = {1'b1, m};
            sh  = 5'd0;
            rm  = 24'd0;
            hf  = 24'd0;
            q   = 11'd0;
            if (e == 8'hff)
            begin
                h = (m != 23'd0) ? 15'h7e00 : 15'h7c00;
            end
            else if (e > 8'd142)
            begin
                h = 15'h7c00;
            end
            else if (e >= 8'd113)
            begin
                h = {5'(e - 8'd112), m[22:13]};
                if (rem > 13'h1000 || (rem == 13'h1000 && h[0]))
                begin
                    h = h + 15'd1;
                end
            end
            else if (e >= 8'd102)
            begin
                sh = 5'(8'd126 - e);
                hf = 24'd1 << (sh - 5'd1);
                rm = sig & ((24'd1 << sh) - 24'd1);
                q  = 11'(sig >> sh);
                h  = {4'd0, q};
                if (rm > hf || (rm == hf && q[0]))
                begin
                    h = h + 15'd1;
                end
            end
            narrow_to_half = {sgn, h};
        end
    endfunction

    function automatic logic [2:0] classify_half(input logic [15:0] h);
        begin
            if (h[14:0] == 15'd0)
            begin
                classify_half = CLS_ZERO;
            end
            else if (h[14:10] == 5'h1f)
            begin
                if (h[9:0] != 10'd0)
                begin
                    classify_half = CLS_NAN;
                end
                else
                begin
                    classify_half = h[15] ? CLS_NEG_INF : CLS_POS_INF;
                end
            end
            else
            begin
                classify_half = CLS_FINITE;
            end
        end
    endfunction

    function automatic logic [63:0] widen_half(input logic [15:0] h, input logic wide);
        logic        sgn;
        logic [4:0]  ex;
        logic [9:0]  mn;
        logic [3:0]  p;
        logic [10:0] e_out;
        logic [9:0]  mnorm;
        begin
            sgn   = h[15];
            ex    = h[14:10];
            mn    = h[9:0];
            p     = 4'd0;
            e_out = 11'd0;
            mnorm = 10'd0;
            for (int i = 0; i < 10; i++)
            begin
                if (mn[i])
                begin
                    p = 4'(i);
                end
            end
            if (ex == 5'h1f)
            begin
                if (mn != 10'd0)
                begin
                    widen_half = wide ? 64'h7ff8000000000000 : 64'h7fc00000;
                end
                else
                begin
                    widen_half = wide ? {sgn, 63'h7ff0000000000000}
                                      : {32'd0, sgn, 31'h7f800000};
                end
            end
            else if (ex == 5'd0 && mn == 10'd0)
            begin
                widen_half = wide ? {sgn, 63'd0} : {32'd0, sgn, 31'd0};
            end
            else
            begin
                if (ex == 5'd0)
                begin
                    mnorm = 10'(mn << (4'd10 - p));
                    e_out = wide ? 11'(p) + 11'd999 : 11'(p) + 11'd103;
                end
                else
                begin
                    mnorm = mn;
                    e_out = wide ? 11'(ex) + 11'd1008 : 11'(ex) + 11'd112;
                end
                widen_half = wide ? {sgn, e_out, mnorm, 42'd0}
                                  : {32'd0, sgn, e_out[7:0], mnorm, 13'd0};
            end
        end
    endfunction

endpackage

/* hw/rtl/half_precision_format_converter.sv */
// Top level: registered binary32/binary16/binary64 format converter
// An accepted item enters the input register, then is converted into the result register.
// Throughput: one item per cycle unless the output stalls; conversion is one pass of logic.
// Stall on the output propagates to the input only when both registers are full.
// Reset clears the valid flags only; payload registers are not reset.
module half_precision_format_converter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  hpfc_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output hpfc_pkg::out_item_t out_item
);

    hpfc_pkg::in_item_t  src_reg;
    logic                src_valid_reg;
    hpfc_pkg::out_item_t res_reg;
    logic                res_valid_reg;
    hpfc_pkg::out_item_t res_next;
    logic [15:0]         half;
    logic                res_load;

    assign res_load  = !res_valid_reg || !out_stall;
    assign in_stall  = src_valid_reg && !res_load;
    assign out_valid = res_valid_reg;
    assign out_item  = res_reg;

    always_comb
    begin
        half     = src_reg.operand_bits[15:0];
        res_next = '0;
        case (src_reg.action)
            hpfc_pkg::ACT_NARROW:
            begin
                half = hpfc_pkg::narrow_to_half(src_reg.operand_bits);
                res_next.result_bits = {48'd0, half};
                res_next.half_class  = hpfc_pkg::classify_half(half);
            end
            hpfc_pkg::ACT_WIDEN32, hpfc_pkg::ACT_WIDEN64:
            begin
                res_next.result_bits = hpfc_pkg::widen_half(half,
                    src_reg.action == hpfc_pkg::ACT_WIDEN64);
                res_next.half_class  = hpfc_pkg::classify_half(half);
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                src_valid_reg <= in_valid;
            end
            if (res_load)
            begin
                res_valid_reg <= src_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            src_reg <= in_item;
        end
        if (res_load && src_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

endmodule
